// ===== design/htbd_pkg.sv =====
package htbd_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int BYTE_BITS    = 8;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CODE_W = MAX_CODE_LEN;
  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int NB_W   = $clog2(BYTE_BITS + 1);

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_DATA  = 2'd2;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef struct packed {
    logic rdy;
    logic lat;
    logic clr;
    logic scan;
    logic wr;
    logic step;
    logic commit;
    logic push;
    logic push_last;
    logic pend_clr;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_req;
    logic       ld_ok;
    logic       scan_done;
    logic       scan_hit;
    logic       eval_res;
    logic       bits_empty;
    logic       pend_vld;
    logic       out_free;
  } sts_t;

endpackage

// ===== design/htbd_in_if.sv =====
interface htbd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  entry_symbol;
  logic [5:0]  entry_length;
  logic [31:0] entry_code;
  logic [7:0]  data_byte;
  logic [3:0]  valid_bits;

  modport source (output valid, req_type, entry_symbol, entry_length, entry_code,
                  data_byte, valid_bits, input ready);
  modport sink (input valid, req_type, entry_symbol, entry_length, entry_code,
                data_byte, valid_bits, output ready);
endinterface

// ===== design/htbd_out_if.sv =====
interface htbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_out;
  logic       status;
  logic       last;

  modport source (output valid, symbol_out, status, last, input ready);
  modport sink (input valid, symbol_out, status, last, output ready);
endinterface

// ===== design/htbd_ctrl.sv =====
module htbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  htbd_pkg::sts_t sts_i,
  output htbd_pkg::cmd_t cmd_o
);
  import htbd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LD_CHK, S_LD_SCAN, S_BIT, S_D_SCAN, S_D_EVAL, S_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.rdy = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.lat = 1'b1;
          if (sts_i.in_req == REQ_CLEAR) begin
            cmd_o.clr = 1'b1;
          end else if (sts_i.in_req == REQ_LOAD) begin
            state_d = S_LD_CHK;
          end else if (sts_i.in_req == REQ_DATA) begin
            state_d = S_BIT;
          end
        end
      end
      S_LD_CHK: begin
        if (sts_i.ld_ok) begin
          cmd_o.scan = 1'b1;
          state_d    = S_LD_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LD_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.wr = !sts_i.scan_hit;
          state_d  = S_IDLE;
        end
      end
      S_BIT: begin
        if (sts_i.bits_empty) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.step = 1'b1;
          cmd_o.scan = 1'b1;
          state_d    = S_D_SCAN;
        end
      end
      S_D_SCAN: begin
        if (sts_i.scan_done) state_d = S_D_EVAL;
      end
      S_D_EVAL: begin
        if (!sts_i.eval_res || !sts_i.pend_vld) begin
          cmd_o.commit = 1'b1;
          state_d      = S_BIT;
        end else if (sts_i.out_free) begin
          // older result goes out, new one becomes pending
          cmd_o.commit = 1'b1;
          cmd_o.push   = 1'b1;
          state_d      = S_BIT;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_vld) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          cmd_o.pend_clr  = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/htbd_datapath.sv =====
module htbd_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  htbd_pkg::cmd_t cmd_i,
  output htbd_pkg::sts_t sts_o,
  input  logic           in_valid_i,
  input  logic [1:0]     req_type_i,
  input  logic [7:0]     entry_symbol_i,
  input  logic [5:0]     entry_length_i,
  input  logic [31:0]    entry_code_i,
  input  logic [7:0]     data_byte_i,
  input  logic [3:0]     valid_bits_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [7:0]     symbol_out_o,
  output logic           status_o,
  output logic           last_o
);
  import htbd_pkg::*;

  logic [CODE_W-1:0] mem_code [TABLE_DEPTH];
  logic [LEN_W-1:0]  mem_len  [TABLE_DEPTH];
  logic [7:0]        mem_sym  [TABLE_DEPTH];

  logic [CNT_W-1:0]  count_q;
  logic [CODE_W-1:0] part_code_q;
  logic [LEN_W-1:0]  part_len_q;
  logic [CODE_W-1:0] cand_code_q;
  logic [LEN_W-1:0]  cand_len_q;
  logic [5:0]        ld_len_q;
  logic [7:0]        ld_sym_q;
  logic [7:0]        byte_q;
  logic [NB_W-1:0]   bits_q;

  logic [CNT_W-1:0]  ra_q;
  logic              rv_q;
  logic              hit_q;
  logic [7:0]        hit_sym_q;
  logic [CODE_W-1:0] rd_code_q;
  logic [LEN_W-1:0]  rd_len_q;
  logic [7:0]        rd_sym_q;

  logic              pend_vld_q;
  logic [7:0]        pend_sym_q;
  logic              pend_st_q;
  logic              out_vld_q;
  logic [7:0]        out_sym_q;
  logic              out_st_q;
  logic              out_last_q;

  logic [CODE_W-1:0] in_mask;
  logic              full;
  logic              eval_res;
  logic              out_free;
  logic              match;

  assign in_mask  = ~({CODE_W{1'b1}} << entry_length_i);
  assign full     = int'(cand_len_q) >= MAX_CODE_LEN;
  assign eval_res = hit_q || full;
  assign out_free = !out_vld_q || out_ready_i;
  assign match    = rv_q && (rd_len_q == cand_len_q) && (rd_code_q == cand_code_q);

  assign sts_o.in_valid   = in_valid_i;
  assign sts_o.in_req     = req_type_i;
  assign sts_o.ld_ok      = (ld_len_q != 6'd0) && (int'(ld_len_q) <= MAX_CODE_LEN) &&
                            (int'(count_q) < TABLE_DEPTH);
  assign sts_o.scan_done  = (ra_q >= count_q) && !rv_q;
  assign sts_o.scan_hit   = hit_q;
  assign sts_o.eval_res   = eval_res;
  assign sts_o.bits_empty = (bits_q == '0);
  assign sts_o.pend_vld   = pend_vld_q;
  assign sts_o.out_free   = out_free;

  // table memory, one read port for the scan, one write port for loads
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_code[count_q[ADDR_W-1:0]] <= cand_code_q;
      mem_len[count_q[ADDR_W-1:0]]  <= cand_len_q;
      mem_sym[count_q[ADDR_W-1:0]]  <= ld_sym_q;
    end
    rd_code_q <= mem_code[ra_q[ADDR_W-1:0]];
    rd_len_q  <= mem_len[ra_q[ADDR_W-1:0]];
    rd_sym_q  <= mem_sym[ra_q[ADDR_W-1:0]];
  end

  // scan walks entries 0..count-1, one read per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_q  <= '0;
      rv_q  <= 1'b0;
      hit_q <= 1'b0;
    end else if (cmd_i.scan) begin
      ra_q  <= '0;
      rv_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      if (ra_q < count_q) begin
        ra_q <= ra_q + CNT_W'(1);
        rv_q <= 1'b1;
      end else begin
        rv_q <= 1'b0;
      end
      if (match) hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) hit_sym_q <= rd_sym_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      part_code_q <= '0;
      part_len_q  <= '0;
      bits_q      <= '0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        count_q     <= '0;
        part_code_q <= '0;
        part_len_q  <= '0;
      end
      if (cmd_i.wr) count_q <= count_q + CNT_W'(1);
      if (cmd_i.lat) begin
        bits_q <= (valid_bits_i > 4'(BYTE_BITS)) ? NB_W'(BYTE_BITS) : NB_W'(valid_bits_i);
      end else if (cmd_i.step) begin
        bits_q <= bits_q - NB_W'(1);
      end
      if (cmd_i.commit) begin
        if (eval_res) begin
          part_code_q <= '0;
          part_len_q  <= '0;
          pend_vld_q  <= 1'b1;
        end else begin
          part_code_q <= cand_code_q;
          part_len_q  <= cand_len_q;
        end
      end
      if (cmd_i.pend_clr) pend_vld_q <= 1'b0;
      if (cmd_i.push) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat) begin
      cand_code_q <= CODE_W'(entry_code_i) & in_mask;
      cand_len_q  <= LEN_W'(entry_length_i);
      ld_len_q    <= entry_length_i;
      ld_sym_q    <= entry_symbol_i;
      byte_q      <= data_byte_i;
    end else if (cmd_i.step) begin
      cand_code_q <= {part_code_q[CODE_W-2:0], byte_q[7]};
      cand_len_q  <= part_len_q + LEN_W'(1);
      byte_q      <= {byte_q[6:0], 1'b0};
    end
    if (cmd_i.push) begin
      out_sym_q  <= pend_sym_q;
      out_st_q   <= pend_st_q;
      out_last_q <= cmd_i.push_last;
    end
    if (cmd_i.commit && eval_res) begin
      pend_sym_q <= hit_q ? hit_sym_q : 8'd0;
      pend_st_q  <= hit_q ? ST_OK : ST_ERR;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign symbol_out_o = out_sym_q;
  assign status_o     = out_st_q;
  assign last_o       = out_last_q;

endmodule

// ===== design/huffman_table_bit_decoder_top.sv =====
// Huffman decoder against a loaded code table. A clear leaves the block ready
// for the next item. A load runs a duplicate check that walks the table, unless
// the length or the fill count rejects it up front, and each bit of a data byte
// walks the stored entries one per cycle through the single table read port. A
// stalled sink holds the decoder until the pending result can move out.
// A decoded symbol is held back until the next one is found or the byte ends,
// so last can be marked; the output register lets a result wait for the sink.
// The table needs no clearing pass: only entries below the fill count are read.
module huffman_table_bit_decoder_top (
  input logic            clk_i,
  input logic            rst_ni,
  htbd_in_if.sink        in_if,
  htbd_out_if.source     out_if
);
  import htbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign in_if.ready = cmd.rdy;

  htbd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  htbd_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_valid_i     (in_if.valid),
    .req_type_i     (in_if.req_type),
    .entry_symbol_i (in_if.entry_symbol),
    .entry_length_i (in_if.entry_length),
    .entry_code_i   (in_if.entry_code),
    .data_byte_i    (in_if.data_byte),
    .valid_bits_i   (in_if.valid_bits),
    .out_ready_i    (out_if.ready),
    .out_valid_o    (out_if.valid),
    .symbol_out_o   (out_if.symbol_out),
    .status_o       (out_if.status),
    .last_o         (out_if.last)
  );

endmodule

// ===== design/htbd_checker.sv =====
module htbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] req_type_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] symbol_out_i,
  input logic       status_i
);
  import htbd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped during stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(symbol_out_i) && $stable(status_i))
    else $error("output payload changed during stall");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_ERR |-> symbol_out_i == 8'd0)
    else $error("error result carries nonzero symbol");

  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && req_type_i == REQ_DATA |=> !in_ready_i)
    else $error("ready right after data byte transfer");

  a_clear_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && req_type_i == REQ_CLEAR |=> in_ready_i)
    else $error("clear did not complete in one cycle");

endmodule

bind huffman_table_bit_decoder_top htbd_checker u_htbd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .req_type_i   (in_if.req_type),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .symbol_out_i (out_if.symbol_out),
  .status_i     (out_if.status)
);

// ===== tb/huffman_table_bit_decoder_top_tb.sv =====
module huffman_table_bit_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htbd_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int IDLE_LIMIT = 30000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS = 30;

  typedef struct {
    logic [7:0] symbol;
    logic       status;
    logic       last;
  } decode_res_t;

  class decode_scoreboard;
    logic [31:0] codes[TABLE_DEPTH];
    logic [5:0]  lens[TABLE_DEPTH];
    logic [7:0]  syms[TABLE_DEPTH];
    int          fill;
    logic [31:0] pcode;
    int          plen;
    decode_res_t pending[$];
    int          errors;
    int          checked;
    int          err_results;

    function void clear();
      fill = 0;
      pcode = '0;
      plen = 0;
    endfunction

    function int lookup(logic [31:0] code, int len);
      for (int i = 0; i < fill; i++)
        if (int'(lens[i]) == len && codes[i] == code) return i;
      return -1;
    endfunction

    function void load(logic [7:0] sym, logic [5:0] len, logic [31:0] code);
      logic [31:0] mask;
      mask = (len >= 32) ? '1 : ((32'h1 << len) - 32'h1);
      if (len == 0 || len > MAX_CODE_LEN) return;
      if (fill >= TABLE_DEPTH) return;
      if (lookup(code & mask, int'(len)) >= 0) return;
      codes[fill] = code & mask;
      lens[fill] = len;
      syms[fill] = sym;
      fill++;
    endfunction

    function void decode(logic [7:0] dbyte, logic [3:0] vb);
      int nb;
      int start;
      int pos;
      decode_res_t r;
      nb = (vb > BYTE_BITS) ? BYTE_BITS : int'(vb);
      start = pending.size();
      for (int b = 0; b < nb; b++) begin
        pcode = {pcode[30:0], dbyte[7]};
        dbyte = dbyte << 1;
        plen++;
        pos = lookup(pcode, plen);
        if (pos >= 0) begin
          r.symbol = syms[pos];
          r.status = ST_OK;
          r.last = 1'b0;
          pending.push_back(r);
          pcode = '0;
          plen = 0;
        end else if (plen >= MAX_CODE_LEN) begin
          r.symbol = '0;
          r.status = ST_ERR;
          r.last = 1'b0;
          pending.push_back(r);
          pcode = '0;
          plen = 0;
        end
      end
      if (pending.size() > start) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void note_item(logic [1:0] req, logic [7:0] sym, logic [5:0] len,
                            logic [31:0] code, logic [7:0] dbyte, logic [3:0] vb);
      case (req)
        REQ_CLEAR: clear();
        REQ_LOAD: load(sym, len, code);
        REQ_DATA: decode(dbyte, vb);
        default: ;
      endcase
    endfunction

    function void check_result(logic [7:0] sym, logic st, logic lst);
      decode_res_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result: symbol_out=%0h status=%0b last=%0b", sym, st, lst);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.status == ST_ERR) err_results++;
      if (sym !== e.symbol) begin
        $error("symbol_out: expected %0h, actual %0h", e.symbol, sym);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0b, actual %0b", e.status, st);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  htbd_in_if in_if ();
  htbd_out_if out_if ();
  decode_scoreboard sb = new();
  int items_sent = 0;
  int idle_cnt = 0;
  bit no_idle = 1'b0;

  always #1 clk_i = ~clk_i;

  huffman_table_bit_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = REQ_CLEAR;
    in_if.entry_symbol = '0;
    in_if.entry_length = '0;
    in_if.entry_code = '0;
    in_if.data_byte = '0;
    in_if.valid_bits = '0;
    out_if.ready = 1'b0;
  end

  task automatic send(logic [1:0] req, logic [7:0] sym, logic [5:0] len,
                      logic [31:0] code, logic [7:0] dbyte, logic [3:0] vb);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= req;
    in_if.entry_symbol <= sym;
    in_if.entry_length <= len;
    in_if.entry_code <= code;
    in_if.data_byte <= dbyte;
    in_if.valid_bits <= vb;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(req, sym, len, code, dbyte, vb);
    items_sent++;
  endtask

  task automatic load(logic [7:0] sym, logic [5:0] len, logic [31:0] code);
    send(REQ_LOAD, sym, len, code, 8'($urandom), 4'($urandom));
  endtask

  task automatic data(logic [7:0] dbyte, logic [3:0] vb);
    send(REQ_DATA, 8'($urandom), 6'($urandom), $urandom, dbyte, vb);
  endtask

  task automatic clear();
    send(REQ_CLEAR, 8'($urandom), 6'($urandom), $urandom, 8'($urandom), 4'($urandom));
  endtask

  // sink side: random stalls, one long hold-off to back up the input
  initial begin : sink_proc
    int gap;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (!held && sb.checked == 30) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_result(out_if.symbol_out, out_if.status, out_if.last);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stim_proc
    int n;
    int k;
    logic [5:0] len;
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: 32 bits with no match give one error
    repeat (4) data(8'hFF, 4'd8);
    // a full-length code matches on the 32nd bit
    load(8'hEE, 6'd32, 32'hA5A5A5A5);
    repeat (4) data(8'hA5, 4'd8);
    clear();
    load(8'h41, 6'd1, 32'h0);
    load(8'h42, 6'd2, 32'h2);
    load(8'h43, 6'd3, 32'h6);
    load(8'h44, 6'd3, 32'hFFFFFFFF);   // upper code bits dropped
    load(8'h55, 6'd1, 32'hFFFFFFFE);   // duplicate of first entry
    load(8'h66, 6'd0, 32'h1);
    load(8'h77, 6'd33, 32'h1);
    load(8'h88, 6'd63, 32'h1);
    data(8'h5B, 4'd8);
    data(8'hFF, 4'd0);
    data(8'h80, 4'd1);                 // completes the partial code 11 left by 5B
    load(8'h99, 6'd4, 32'h9);          // new entry while no partial code is held
    data(8'h00, 4'd9);
    send(REQ_NONE, 8'hFF, 6'h3F, 32'hFFFFFFFF, 8'hFF, 4'hF);
    data(8'hFF, 4'd15);
    data(8'hC0, 4'd2);
    clear();

    // random: mostly table builds followed by streams, some noise
    n = 0;
    while (n < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 2) begin
        send(2'($urandom_range(0, 3)), 8'($urandom), 6'($urandom), $urandom,
             8'($urandom), 4'($urandom));
        n++;
      end else begin
        clear();
        k = $urandom_range(1, 12);
        for (int i = 0; i < k; i++) begin
          len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(6, 32))
                                            : 6'($urandom_range(1, 4));
          load(8'($urandom), len, $urandom);
        end
        n += k + 1;
        k = $urandom_range(4, 14);
        for (int i = 0; i < k; i++)
          data(8'($urandom), ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd8);
        n += k;
      end
      no_idle = (n >= 8 && n < 20);
    end
    no_idle = 1'b0;

    // table full: extra loads are dropped
    clear();
    for (int i = 0; i < TABLE_DEPTH + 4; i++) load(i[7:0] ^ 8'h5A, 6'd8, 32'(i));
    repeat (3) data(8'($urandom), 4'd8);

    if (items_sent > 0) in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d items, checked %0d results (%0d no-match errors).",
             items_sent, sb.checked, sb.err_results);
    $display("Covered clears, loads incl. duplicates/invalid lengths, full table, odd bit counts.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
